// File: sv/dmwpe_pkg.sv
// Shared types, character codes and helpers for the memory write packet encoder.
package dmwpe_pkg;

    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 32;
    localparam int CFG_W     = 13;
    localparam int NIB_W     = 4;
    localparam int NIB_CNT   = ADDR_W / NIB_W;
    localparam int NIB_CNT_W = $clog2(NIB_CNT);

    localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(256);

    localparam logic [BYTE_W-1:0] CH_X      = 8'h58;  // 'X'
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2c;  // ','
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3a;  // ':'
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;  // '$'
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;  // '#'
    localparam logic [BYTE_W-1:0] CH_ESC    = 8'h7d;
    localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;

    // One output word.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              packet_end;
        logic              run_last;
    } t_out_word;

    // Status of the hex digit scanner for the current nibble.
    typedef struct packed {
        logic              emit;
        logic              last;
        logic [BYTE_W-1:0] ch;
    } t_hex_st;

    function automatic logic [BYTE_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
        logic [BYTE_W-1:0] res;
        if (nib < NIB_W'(10)) begin
            res = 8'h30 + BYTE_W'(nib);
        end else begin
            res = 8'h57 + BYTE_W'(nib);  // 'a' - 10
        end
        return res;
    endfunction

    function automatic logic needs_escape(input logic [BYTE_W-1:0] b);
        return (b == CH_DOLLAR) || (b == CH_HASH) || (b == CH_ESC);
    endfunction

endpackage

// File: sv/debug_memory_write_packet_encoder_unit.sv
// Memory write packet encoder: segment bytes in, binary X write packet words out.
//
// One input word is taken while the block is idle; the next one is not taken until the
// last word of the current byte has gone into the output register. A byte that stays
// within an open packet sends one data word, or two if it must be escaped. A byte that
// opens a packet also produces the header first: 'X', eight nibble steps of the shared
// hex scanner over the address, ',', eight steps over the length, ':'. Leading zero
// nibbles take a scanner step but send no word. Every step waits while the output side
// stalls. Throughput is set by the single output register (one word per cycle when not
// stalled) and the nibble scanner. A byte outside a segment is taken and sends nothing.
module debug_memory_write_packet_encoder_unit
    import dmwpe_pkg::*;
#(
    parameter int MAX_PACKET = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_seg_first,
    input  logic [ADDR_W-1:0] i_seg_address,
    input  logic [LEN_W-1:0]  i_seg_length,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_packet_end,
    output logic              o_run_last
);

    localparam int PR_W = $clog2(MAX_PACKET + 1);
    localparam logic [LEN_W-1:0] MAX_PKT_L = LEN_W'(MAX_PACKET);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_HDR_X = 8'b0000_0010,
        S_ADDR  = 8'b0000_0100,
        S_COMMA = 8'b0000_1000,
        S_LEN   = 8'b0001_0000,
        S_COLON = 8'b0010_0000,
        S_DATA  = 8'b0100_0000,
        S_ESC2  = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_cfg;
    logic [ADDR_W-1:0] r_next_addr;
    logic [LEN_W-1:0]  r_seg_rem;
    logic [PR_W-1:0]   r_prem;
    logic [PR_W-1:0]   r_chunk;
    logic [BYTE_W-1:0] r_byte;
    logic              r_pend;

    logic              w_acc;
    logic [ADDR_W-1:0] w_addr;
    logic [LEN_W-1:0]  w_seg_rem;
    logic [PR_W-1:0]   w_prem;
    logic              w_new_pkt;
    logic [LEN_W-1:0]  w_cfg_l;
    logic [LEN_W-1:0]  w_ps;
    logic [LEN_W-1:0]  w_chunk_l;
    logic [PR_W-1:0]   w_pcnt;

    logic              w_take;
    logic              w_push;
    t_out_word         w_word;
    t_out_word         w_oword;
    logic              w_hex_load;
    logic [ADDR_W-1:0] w_hex_val;
    logic              w_hex_step;
    t_hex_st           w_hex;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;

    // effective segment state for the incoming byte
    assign w_addr    = i_seg_first ? i_seg_address : r_next_addr;
    assign w_seg_rem = i_seg_first ? i_seg_length  : r_seg_rem;
    assign w_prem    = i_seg_first ? '0            : r_prem;
    assign w_new_pkt = (w_prem == '0);

    // packet size clamped to 1..MAX_PACKET, then limited by the segment
    assign w_cfg_l   = LEN_W'(r_cfg);
    always_comb begin
        priority if (w_cfg_l == '0) begin
            w_ps = LEN_W'(1);
        end else if (w_cfg_l > MAX_PKT_L) begin
            w_ps = MAX_PKT_L;
        end else begin
            w_ps = w_cfg_l;
        end
    end
    assign w_chunk_l = (w_seg_rem < w_ps) ? w_seg_rem : w_ps;
    assign w_pcnt    = w_new_pkt ? w_chunk_l[PR_W-1:0] : w_prem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_addr <= '0;
            r_seg_rem   <= '0;
            r_prem      <= '0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                if (w_seg_rem != '0) begin
                    r_next_addr <= w_addr + ADDR_W'(1);
                    r_seg_rem   <= w_seg_rem - LEN_W'(1);
                    r_prem      <= w_pcnt - PR_W'(1);
                end else begin
                    r_next_addr <= w_addr;
                    r_seg_rem   <= '0;
                    r_prem      <= w_prem;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_byte  <= i_data_byte;
            r_chunk <= w_chunk_l[PR_W-1:0];
            r_pend  <= (w_pcnt == PR_W'(1));
        end
    end

    always_comb begin
        n_state         = r_state;
        w_push          = 1'b0;
        w_word          = '0;
        w_hex_load      = 1'b0;
        w_hex_val       = ADDR_W'(r_chunk);
        w_hex_step      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && (w_seg_rem != '0)) begin
                    w_hex_load = 1'b1;
                    w_hex_val  = w_addr;
                    n_state    = w_new_pkt ? S_HDR_X : S_DATA;
                end
            end
            S_HDR_X: begin
                if (w_take) begin
                    w_push          = 1'b1;
                    w_word.out_byte = CH_X;
                    n_state         = S_ADDR;
                end
            end
            S_ADDR: begin
                if (w_take) begin
                    w_hex_step      = 1'b1;
                    w_push          = w_hex.emit;
                    w_word.out_byte = w_hex.ch;
                    if (w_hex.last) begin
                        n_state = S_COMMA;
                    end
                end
            end
            S_COMMA: begin
                if (w_take) begin
                    w_push          = 1'b1;
                    w_word.out_byte = CH_COMMA;
                    w_hex_load      = 1'b1;
                    n_state         = S_LEN;
                end
            end
            S_LEN: begin
                if (w_take) begin
                    w_hex_step      = 1'b1;
                    w_push          = w_hex.emit;
                    w_word.out_byte = w_hex.ch;
                    if (w_hex.last) begin
                        n_state = S_COLON;
                    end
                end
            end
            S_COLON: begin
                if (w_take) begin
                    w_push          = 1'b1;
                    w_word.out_byte = CH_COLON;
                    n_state         = S_DATA;
                end
            end
            S_DATA: begin
                if (w_take) begin
                    w_push = 1'b1;
                    if (needs_escape(r_byte)) begin
                        w_word.out_byte = CH_ESC;
                        n_state         = S_ESC2;
                    end else begin
                        w_word.out_byte   = r_byte;
                        w_word.packet_end = r_pend;
                        w_word.run_last   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end
            end
            S_ESC2: begin
                if (w_take) begin
                    w_push            = 1'b1;
                    w_word.out_byte   = r_byte ^ ESC_XOR;
                    w_word.packet_end = r_pend;
                    w_word.run_last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    dmwpe_hex u_hex (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_hex_load),
        .i_load_val (w_hex_val),
        .i_step     (w_hex_step),
        .o_st       (w_hex)
    );

    dmwpe_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_word     (w_word),
        .o_can_take (w_take),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_word     (w_oword)
    );

    assign o_out_byte   = w_oword.out_byte;
    assign o_packet_end = w_oword.packet_end;
    assign o_run_last   = w_oword.run_last;

endmodule

// File: sv/dmwpe_hex.sv
// Nibble scanner: walks a 32-bit value from the top, one nibble per step, flags digits to print.
module dmwpe_hex
    import dmwpe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [ADDR_W-1:0] i_load_val,
    input  logic              i_step,
    output t_hex_st           o_st
);

    logic [ADDR_W-1:0]    r_sh;
    logic [NIB_CNT_W-1:0] r_cnt;
    logic                 r_started;
    logic [NIB_W-1:0]     w_digit;
    logic                 w_last;

    assign w_digit = r_sh[ADDR_W-1 -: NIB_W];
    assign w_last  = (r_cnt == NIB_CNT_W'(NIB_CNT - 1));

    // leading zeros are skipped, but the last nibble always prints
    assign o_st.emit = (w_digit != '0) || r_started || w_last;
    assign o_st.last = w_last;
    assign o_st.ch   = hex_char(w_digit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_started <= 1'b0;
        end else if (i_load) begin
            r_cnt     <= '0;
            r_started <= 1'b0;
        end else if (i_step) begin
            r_cnt     <= r_cnt + NIB_CNT_W'(1);
            r_started <= r_started || o_st.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sh <= i_load_val;
        end else if (i_step) begin
            r_sh <= r_sh << NIB_W;
        end
    end

endmodule

// File: sv/dmwpe_obuf.sv
// One-entry output register between the sequencer and the output channel.
module dmwpe_obuf
    import dmwpe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_word i_word,
    output logic      o_can_take,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    logic      r_valid;
    t_out_word r_word;

    assign o_can_take = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_push) begin
            r_word <= i_word;
        end
    end

endmodule

// File: sv/dmwpe_chk.sv
// Port-level checks for the memory write packet encoder, bound to the top level.
module dmwpe_chk
    import dmwpe_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [BYTE_W-1:0] o_out_byte,
    input logic              o_packet_end,
    input logic              o_run_last
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) &&
        $stable(o_packet_end) && $stable(o_run_last))
        else $error("output word changed while stalled");

    // a packet only ends on the last word of an input byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_packet_end |-> o_run_last)
        else $error("packet_end without run_last");

    // while taking input, only the last word of the previous byte may be pending
    a_ready_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && o_valid |-> o_run_last)
        else $error("input ready with a byte still being sent");

    // the next byte cannot produce a word in the cycle right after the last one drains
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && o_valid && o_run_last && i_ready |=> !o_valid)
        else $error("word appeared without a new byte");

endmodule

bind debug_memory_write_packet_encoder_unit dmwpe_chk u_chk (.*);

// File: dv/dmwpe_sb_pkg.sv
// Scoreboard for the memory write packet encoder: packet prediction and word checking.
package dmwpe_sb_pkg;
    import dmwpe_pkg::*;

    localparam int unsigned MAX_PKT = 4096;
    localparam string HEX_DIGITS = "0123456789abcdef";

    class packet_scoreboard;
        t_out_word         expected_words[$];
        int unsigned       errors;
        int unsigned       words_seen;
        logic [CFG_W-1:0]  packet_size;
        logic [ADDR_W-1:0] next_addr;
        logic [LEN_W-1:0]  seg_left;
        int unsigned       pkt_left;

        function new();
            errors      = 0;
            words_seen  = 0;
            packet_size = CFG_RESET;
            next_addr   = '0;
            seg_left    = '0;
            pkt_left    = 0;
        endfunction

        function void report_mismatch(input string msg);
            if (errors < 100) begin
                $display("tb_top: mismatch at output word %0d: %s", words_seen, msg);
            end
            errors++;
        endfunction

        function void set_packet_size(input logic [CFG_W-1:0] v);
            packet_size = v;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void push_char(input logic [BYTE_W-1:0] c);
            t_out_word w;
            w.out_byte   = c;
            w.packet_end = 1'b0;
            w.run_last   = 1'b0;
            expected_words.push_back(w);
        endfunction

        // lower-case hex, leading zeros dropped, zero itself printed as one digit
        function void push_hex(input logic [31:0] v);
            bit         started;
            logic [3:0] nib;
            started = 1'b0;
            for (int i = 7; i >= 0; i--) begin
                nib = v[i*4 +: 4];
                if (nib != 4'd0 || started || i == 0) begin
                    push_char(HEX_DIGITS[nib]);
                    started = 1'b1;
                end
            end
        endfunction

        // Returns how many output words this input word is expected to cause.
        function int note_input(input logic [BYTE_W-1:0] b, input logic first,
                                input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
            int unsigned size;
            logic [31:0] chunk;
            int          n0;
            int          last;
            if (first) begin
                next_addr = addr;
                seg_left  = len;
                pkt_left  = 0;
            end
            if (seg_left == '0) return 0;
            n0 = expected_words.size();
            if (pkt_left == 0) begin
                size = packet_size;
                if (size == 0) size = 1;
                if (size > MAX_PKT) size = MAX_PKT;
                chunk = (seg_left < size) ? seg_left : size;
                push_char(CH_X);
                push_hex(next_addr);
                push_char(CH_COMMA);
                push_hex(chunk);
                push_char(CH_COLON);
                pkt_left = chunk;
            end
            if (b == CH_DOLLAR || b == CH_HASH || b == CH_ESC) begin
                push_char(CH_ESC);
                push_char(b ^ ESC_XOR);
            end else begin
                push_char(b);
            end
            pkt_left--;
            seg_left--;
            next_addr++;
            last = expected_words.size() - 1;
            if (pkt_left == 0) expected_words[last].packet_end = 1'b1;
            expected_words[last].run_last = 1'b1;
            return expected_words.size() - n0;
        endfunction

        function void check_word(input logic [BYTE_W-1:0] got_byte, input logic got_end,
                                 input logic got_last);
            t_out_word want;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %02h end=%0b last=%0b",
                                          got_byte, got_end, got_last));
            end else begin
                want = expected_words.pop_front();
                if (got_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h", got_byte,
                                              want.out_byte));
                if (got_end !== want.packet_end)
                    report_mismatch($sformatf("packet_end %0b, want %0b", got_end,
                                              want.packet_end));
                if (got_last !== want.run_last)
                    report_mismatch($sformatf("run_last %0b, want %0b", got_last,
                                              want.run_last));
            end
            words_seen++;
        endfunction

        function void check_drained();
            if (expected_words.size() != 0)
                report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
        endfunction
    endclass

endpackage

// File: dv/tb_top.sv
// Top-level testbench for the memory write packet encoder: stimulus, handshakes and checking.
module tb_top;
    import dmwpe_pkg::*;
    import dmwpe_sb_pkg::*;

    localparam int N_ITEMS       = 150;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 250;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata   = '0;
    logic              i_valid       = 1'b0;
    logic [BYTE_W-1:0] i_data_byte   = '0;
    logic              i_seg_first   = 1'b0;
    logic [ADDR_W-1:0] i_seg_address = '0;
    logic [LEN_W-1:0]  i_seg_length  = '0;
    logic              i_ready       = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_packet_end;
    logic              o_run_last;

    packet_scoreboard sb = new();

    bit idle_on    = 1'b1;
    bit hold_req   = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left  = 0;
    int sent_items = 0;

    debug_memory_write_packet_encoder_unit #(
        .MAX_PACKET(MAX_PKT)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_seg_first  (i_seg_first),
        .i_seg_address(i_seg_address),
        .i_seg_length (i_seg_length),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .o_run_last   (o_run_last)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Output side: check accepted words, then pick ready for the next cycle.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_word(o_out_byte, o_packet_end, o_run_last);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !idle_on || ($urandom_range(99) >= 20);
            end
        end
    end

    task automatic push_item(input logic [BYTE_W-1:0] b, input logic first,
                             input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
        if (idle_on) begin
            while ($urandom_range(99) < 20) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_seg_first   <= first;
        i_seg_address <= addr;
        i_seg_length  <= len;
        do @(posedge i_clk); while (!o_ready);
        void'(sb.note_input(b, first, addr, len));
        sent_items++;
    endtask

    // Only while idle: drain, let a dropped word finish, then write.
    task automatic write_packet_size(input logic [CFG_W-1:0] v);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_packet_size(v);
    endtask

    function automatic logic [BYTE_W-1:0] random_data();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(2))
                0:       b = CH_DOLLAR;
                1:       b = CH_HASH;
                default: b = CH_ESC;
            endcase
        end
        return b;
    endfunction

    task automatic random_segment();
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        int unsigned       count;
        int unsigned       kind;
        kind  = $urandom_range(99);
        addr  = ($urandom_range(9) == 0) ? (32'hFFFF_FFF8 | $urandom_range(7)) : $urandom;
        len   = $urandom_range(1, 12);
        count = len;
        if (kind < 8) begin
            // long segment, cut short by the next one
            len   = $urandom | 32'h0001_0000;
            count = $urandom_range(1, 6);
        end else if (kind < 10) begin
            len   = 32'hFFFF_FFFF;
            count = $urandom_range(1, 4);
        end else if (kind < 18) begin
            count = $urandom_range(1, len);
        end else if (kind < 24) begin
            count = len + $urandom_range(1, 3);  // trailing words get dropped
        end else if (kind < 28) begin
            len   = '0;
            count = $urandom_range(1, 3);
        end
        for (int i = 0; i < count; i++) begin
            push_item(random_data(), i == 0, (i == 0) ? addr : $urandom,
                      (i == 0) ? len : $urandom);
        end
    endtask

    initial begin
        int phase;
        phase = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset packet size
        push_item(8'h41, 1'b0, 32'hDEAD_BEEF, 32'h5);        // no open segment
        push_item(8'h42, 1'b1, 32'h0000_1000, 32'h0);        // empty segment
        push_item(8'h00, 1'b1, 32'h0, 32'h3);                // zero address in header
        push_item(CH_DOLLAR, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(8'hFF, 1'b0, 32'h0, 32'h0);
        push_item(CH_HASH, 1'b1, 32'hFFFF_FFFE, 32'h4);      // address wraps
        push_item(CH_ESC, 1'b0, 32'h0, 32'h0);
        push_item(8'h5d, 1'b0, 32'h0, 32'h0);
        push_item(8'h80, 1'b0, 32'h0, 32'h0);
        push_item(8'hAA, 1'b1, 32'h1234_5678, 32'hFFFF_FFFF);
        push_item(CH_ESC, 1'b1, 32'h89AB_CDEF, 32'h2);       // restart mid-segment
        push_item(8'h01, 1'b0, 32'h0, 32'h0);
        push_item(8'h7e, 1'b0, 32'h0, 32'h0);                // past segment end

        write_packet_size(CFG_W'(0));                        // behaves as one
        push_item(8'h10, 1'b1, 32'h10, 32'h3);
        push_item(CH_HASH, 1'b0, 32'h0, 32'h0);
        push_item(8'h7f, 1'b0, 32'h0, 32'h0);

        write_packet_size(CFG_W'(8191));                     // clamps to the max
        push_item(8'h55, 1'b1, 32'h7FFF_FFFF, 32'h2000);
        push_item(8'h24, 1'b0, 32'h0, 32'h0);

        write_packet_size(CFG_W'(MAX_PKT));
        push_item(8'h33, 1'b1, 32'h8000_0000, 32'd5000);

        // random part; the first phases run without idling
        idle_on = 1'b0;
        while (sent_items < N_ITEMS) begin
            case (phase)
                0:       write_packet_size(CFG_W'(1));
                1:       write_packet_size(CFG_W'(2));
                default: write_packet_size(($urandom_range(9) == 0) ?
                                           CFG_W'($urandom_range(0, 8191)) :
                                           CFG_W'($urandom_range(0, 6)));
            endcase
            // receiver stall starts while this phase is still sending
            if (sent_items > 80) hold_req = 1'b1;
            repeat (4) random_segment();
            phase++;
            if (sent_items > 60) idle_on = 1'b1;
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
sv/dmwpe_pkg.sv
sv/dmwpe_hex.sv
sv/dmwpe_obuf.sv
sv/debug_memory_write_packet_encoder_unit.sv
sv/dmwpe_chk.sv
dv/dmwpe_sb_pkg.sv
dv/tb_top.sv
